// ===== src/afc_pkg.sv =====
// ----------------------------------------------------------------------------
// afc_pkg: shared types and constants of the audio FIR convolver
// Request and result payloads, operation codes, and arithmetic widths.
// ----------------------------------------------------------------------------
package afc_pkg;

	localparam int TAPS_DEF = 64;
	localparam int DATA_W   = 16;
	localparam int IDX_W    = 6;
	localparam int CNT_W    = 7;
	localparam int FRAC_W   = 15;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int DIGIT_W  = 4;
	localparam int DIGITS   = DATA_W / DIGIT_W;
	localparam int DIG_CW   = $clog2(DIGITS);
	localparam int SAT_MAX  = 32767;
	localparam int SAT_MIN  = -32768;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_FLUSH  = 2'd2,
		OP_NONE   = 2'd3
	} afc_op_t;

	typedef struct packed {
		afc_op_t                   op;
		logic [IDX_W-1:0]          tap_index;
		logic signed [DATA_W-1:0]  tap_value;
		logic signed [DATA_W-1:0]  sample_in;
	} afc_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  sample_out;
		logic                      clipped;
	} afc_res_t;

	typedef struct packed {
		logic clear;
		logic active;
		logic first;
		logic last;
	} afc_mac_ctrl_t;

endpackage

// ===== src/audio_fir_convolver_core.sv =====
// ----------------------------------------------------------------------------
// audio_fir_convolver_core: direct-form FIR filter for 16-bit audio
// Holds taps and sample history in two memories and computes each output
// with one digit-serial multiply-accumulate unit, saturating to 16 bits.
// ----------------------------------------------------------------------------
// Timing: a sample or flush request walks n = min(tap_count, TAPS) taps, one 4-bit
//   tap digit at a time, then drains and waits in the done state for a free output.
//   A load or ignored request leaves the sequencer idle.
// New requests are taken only while idle: one load per cycle, one sample per result.
// Reset: asynchronous, active low. tap_count returns to 1; afterwards a
//   clearing pass zeroes both memories before requests are taken.
module audio_fir_convolver_core #(
	parameter int TAPS = afc_pkg::TAPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  afc_pkg::afc_req_t             req_data,
	output logic                          res_valid,
	input  logic                          res_ready,
	output afc_pkg::afc_res_t             res_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [afc_pkg::CNT_W-1:0]     cfg_data
);
	import afc_pkg::*;

	localparam int AW    = $clog2(TAPS);
	localparam int NW    = $clog2(TAPS + 1);
	localparam int ACC_W = PROD_W + $clog2(TAPS);
	localparam int Y_W   = ACC_W - FRAC_W;
	localparam logic [AW-1:0]     LAST_ADDR = AW'(TAPS - 1);
	localparam logic [DIG_CW-1:0] LAST_DIG  = DIG_CW'(DIGITS - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_MAC,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// Memories: tap store and circular delay line
	logic [DATA_W-1:0] tap_mem [TAPS];
	logic [DATA_W-1:0] dly_mem [TAPS];

	state_t              state_q;
	logic [CNT_W-1:0]    tap_count_q;
	logic [AW-1:0]       clr_addr_q;
	logic [AW-1:0]       ptr_q;          // address of the newest sample
	logic [AW-1:0]       tap_rd_addr_q;
	logic [AW-1:0]       dly_rd_addr_q;
	logic [NW-1:0]       taps_left_q;
	logic [DIG_CW-1:0]   dig_q;
	logic [DATA_W-1:0]   tap_sh_q;       // tap shifted out one digit per cycle
	logic [DATA_W-1:0]   dly_rd_q;       // sample held for the current tap
	afc_res_t            res_q;
	logic                res_valid_q;

	logic                accept;
	logic [AW-1:0]       ptr_inc;
	logic [AW-1:0]       dly_rd_dec;
	logic [NW-1:0]       n_eff;
	logic                more_taps;
	logic                rd_en;
	logic                tap_we;
	logic [AW-1:0]       tap_wa;
	logic [DATA_W-1:0]   tap_wd;
	logic                dly_we;
	logic [AW-1:0]       dly_wa;
	logic [DATA_W-1:0]   dly_wd;
	logic                res_free;
	afc_mac_ctrl_t       mac_ctrl;
	logic signed [ACC_W-1:0] acc;
	logic signed [Y_W-1:0]   y_sh;
	afc_res_t            res_next;

	// Request and configuration handshakes
	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign cfg_ready = 1'b1;
	assign res_free  = !res_valid_q || res_ready;

	// Address arithmetic: wrap at the delay line length
	assign ptr_inc    = (ptr_q == LAST_ADDR) ? '0 : ptr_q + 1'b1;
	assign dly_rd_dec = (dly_rd_addr_q == '0) ? LAST_ADDR : dly_rd_addr_q - 1'b1;

	// Clamp the tap count to the storage depth
	assign n_eff = (32'(tap_count_q) > TAPS) ? NW'(TAPS) : NW'(tap_count_q);

	assign more_taps = (taps_left_q != '0);

	// Issue a read for the first tap, then one at the last digit of each tap while taps remain
	assign rd_en = (state_q == ST_FETCH)
	            || ((state_q == ST_MAC) && (dig_q == LAST_DIG) && more_taps);

	// Memory write ports: clearing pass, tap load, sample shift-in
	always_comb begin
		tap_we = 1'b0;
		tap_wa = clr_addr_q;
		tap_wd = '0;
		dly_we = 1'b0;
		dly_wa = clr_addr_q;
		dly_wd = '0;
		if (state_q == ST_CLEAR) begin
			tap_we = 1'b1;
			dly_we = 1'b1;
		end else if (accept) begin
			unique case (req_data.op) inside
				OP_LOAD: begin
					tap_we = (32'(req_data.tap_index) < TAPS);
					tap_wa = AW'(req_data.tap_index);
					tap_wd = req_data.tap_value;
				end
				OP_SAMPLE, OP_FLUSH: begin
					dly_we = 1'b1;
					dly_wa = ptr_inc;
					dly_wd = (req_data.op == OP_SAMPLE) ? req_data.sample_in : '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tap_we) begin
			tap_mem[tap_wa] <= tap_wd;
		end
		if (dly_we) begin
			dly_mem[dly_wa] <= dly_wd;
		end
		if (rd_en) begin
			tap_sh_q <= tap_mem[tap_rd_addr_q];
			dly_rd_q <= dly_mem[dly_rd_addr_q];
		end else if (state_q == ST_MAC) begin
			tap_sh_q <= tap_sh_q << DIGIT_W;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= CNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			tap_count_q <= cfg_data;
		end
	end

	// MAC control: clear on a new sample or flush, one digit per cycle in ST_MAC
	always_comb begin
		mac_ctrl.clear  = accept && ((req_data.op == OP_SAMPLE) || (req_data.op == OP_FLUSH));
		mac_ctrl.active = (state_q == ST_MAC);
		mac_ctrl.first  = (dig_q == '0);
		mac_ctrl.last   = (dig_q == LAST_DIG);
	end

	afc_mac #(
		.ACC_W (ACC_W)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.x      ($signed(dly_rd_q)),
		.digit  (tap_sh_q[DATA_W-1 -: DIGIT_W]),
		.acc    (acc)
	);

	// Drop the fraction (floor) and saturate to 16 bits
	assign y_sh = $signed(acc[ACC_W-1:FRAC_W]);

	always_comb begin
		res_next.clipped = 1'b0;
		res_next.sample_out = DATA_W'(y_sh);
		if (y_sh > SAT_MAX) begin
			res_next.sample_out = DATA_W'(SAT_MAX);
			res_next.clipped    = 1'b1;
		end else if (y_sh < SAT_MIN) begin
			res_next.sample_out = DATA_W'(SAT_MIN);
			res_next.clipped    = 1'b1;
		end
	end

	// Sequencer: clear memories, take requests, walk the taps, emit result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_addr_q    <= '0;
			ptr_q         <= '0;
			tap_rd_addr_q <= '0;
			dly_rd_addr_q <= '0;
			taps_left_q   <= '0;
			dig_q         <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (rd_en) begin
				tap_rd_addr_q <= tap_rd_addr_q + 1'b1;
				dly_rd_addr_q <= dly_rd_dec;
				taps_left_q   <= taps_left_q - 1'b1;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && ((req_data.op == OP_SAMPLE) || (req_data.op == OP_FLUSH))) begin
						ptr_q         <= ptr_inc;
						tap_rd_addr_q <= '0;
						dly_rd_addr_q <= ptr_inc;
						taps_left_q   <= n_eff;
						dig_q         <= '0;
						state_q       <= (n_eff == '0) ? ST_DRAIN : ST_FETCH;
					end
				end
				ST_FETCH: begin
					dig_q   <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					dig_q <= dig_q + 1'b1;
					if ((dig_q == LAST_DIG) && !more_taps) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && res_free) begin
			res_q <= res_next;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Checks
	a_clip_at_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_data.clipped) |->
			(res_data.sample_out == 16'sh7FFF || res_data.sample_out == 16'sh8000))
		else $error("clipped result not at a saturation rail");

	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done state");

	a_digit_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC && dig_q == '0) |-> $past(rd_en))
		else $error("first tap digit used without a memory read");

	a_no_request_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> !(accept && $past(state_q) == ST_CLEAR && state_q == ST_CLEAR))
		else $error("request accepted during clearing pass");

endmodule

// ===== src/afc_mac.sv =====
// ----------------------------------------------------------------------------
// afc_mac: digit-serial multiply-accumulate
// Multiplies a sample by a tap one 4-bit tap digit per cycle, most significant
// digit first, and adds each finished product into a wide accumulator.
// ----------------------------------------------------------------------------
module afc_mac #(
	parameter int ACC_W = 2 * afc_pkg::DATA_W + 6
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  afc_pkg::afc_mac_ctrl_t               ctrl,
	input  logic signed [afc_pkg::DATA_W-1:0]    x,
	input  logic [afc_pkg::DIGIT_W-1:0]          digit,
	output logic signed [ACC_W-1:0]              acc
);
	import afc_pkg::*;

	logic signed [DIGIT_W:0]          dig_ext;
	logic signed [DATA_W+DIGIT_W:0]   part;
	logic signed [PROD_W-1:0]         p_next;
	logic signed [PROD_W-1:0]         p_q;
	logic                             pv_q;
	logic signed [ACC_W-1:0]          acc_q;

	// top digit of the tap carries the sign, the rest are plain magnitudes
	assign dig_ext = ctrl.first ? $signed({digit[DIGIT_W-1], digit})
	                            : $signed({1'b0, digit});
	assign part    = x * dig_ext;
	assign p_next  = ctrl.first ? PROD_W'(part)
	                            : (p_q <<< DIGIT_W) + PROD_W'(part);

	always_ff @(posedge clk) begin
		if (ctrl.active) begin
			p_q <= p_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_q  <= 1'b0;
			acc_q <= '0;
		end else if (ctrl.clear) begin
			pv_q  <= 1'b0;
			acc_q <= '0;
		end else begin
			pv_q <= ctrl.active & ctrl.last;
			if (pv_q) begin
				acc_q <= acc_q + ACC_W'(p_q);
			end
		end
	end

	assign acc = acc_q;

endmodule
